### rtl/dotu_pkg.sv
// ----------------------------------------------------------------------------
// dotu_pkg
// Types, codes and constants shared by the timer table unit.
// ----------------------------------------------------------------------------
package dotu_pkg;

   // Default number of timer slots and default rollover window in ms.
   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] DEFAULT_WINDOW = 32'(60 * 60 * 1000);
   localparam logic [63:0] EMPTY_REMAINING = '1;

   // Operation codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_REFRESH = 3'd2,
      OP_RESET   = 3'd3,
      OP_QUERY   = 3'd4,
      OP_EXPIRE  = 3'd5,
      OP_NOP     = 3'd6
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NOT_ACTIVE = 2'd1,
      STS_FULL       = 2'd2,
      STS_NOTHING    = 2'd3
   } status_type;

   // A classified request as held between the front and the back.
   typedef struct packed {
      op_type      op;
      logic [5:0]  slot;
      logic [31:0] period;
      logic        repeat_req;
      logic        restart_now;
      logic [63:0] now;
   } cmd_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic [5:0]  timer_id;
      logic [63:0] remaining;
      logic        any_active;
      logic        front_notice;
      logic        last;
   } rsp_type;

endpackage

### rtl/deadline_ordered_timer_table_unit.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_table_unit
// Table of one-shot and recurring timers ordered by absolute deadline.
// ----------------------------------------------------------------------------
// Requests enter through a queue interface (req_push / req_full) and results
// leave through another (rsp_empty / rsp_pop); every request yields one
// result, except expire, which yields one result per due timer, the final one
// marked by rsp_last, or a single result when none is due. The rollover
// window is written through csr_valid / csr_ready / csr_data; the user must
// write it only while the unit is idle, as the block does not enforce this.
// A front queue of two requests decouples the request side from the executing
// back end, and a two-entry result queue decouples the receiver.
// Query scans the deadline memory, one slot read per cycle, and so do add and
// reset when they run a front check; cancel, refresh and unused codes do not.
// Expire scans the table once for due timers, then once per due timer to
// pick each next one in deadline order, and once to rearm recurring timers;
// with nothing due it answers without further scans. One request runs at a time.
// Reset empties both queues, disarms every timer, clears the notice flag and
// the previous expire time, and restores the default window. When the
// receiver stalls, the result queue fills, the back end holds its result and
// the front queue fills in turn.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_table_unit #(
   parameter int SLOTS = dotu_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_period_ms,
   input  logic        req_repeat_req,
   input  logic        req_restart_now,
   input  logic [63:0] req_now_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_timer_id,
   output logic [63:0] rsp_remaining_ms,
   output logic        rsp_any_active,
   output logic        rsp_front_notice,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   dotu_pkg::cmd_type cmd;
   logic              rsp_push;
   logic              rsp_full;
   dotu_pkg::rsp_type rsp_in;
   dotu_pkg::rsp_type rsp_head;
   logic [31:0]       window_ff;

   // Rollover window register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= dotu_pkg::DEFAULT_WINDOW;
      end else if (csr_valid) begin
         window_ff <= csr_data;
      end
   end

   dotu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_slot        (req_slot),
      .req_period_ms   (req_period_ms),
      .req_repeat_req  (req_repeat_req),
      .req_restart_now (req_restart_now),
      .req_now_ms      (req_now_ms),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   dotu_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .window    (window_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in),
      .rsp_full  (rsp_full)
   );

   dotu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   // Result fields onto their ports.
   assign rsp_status       = rsp_head.status;
   assign rsp_timer_id     = rsp_head.timer_id;
   assign rsp_remaining_ms = rsp_head.remaining;
   assign rsp_any_active   = rsp_head.any_active;
   assign rsp_front_notice = rsp_head.front_notice;
   assign rsp_last         = rsp_head.last;

endmodule

### rtl/dotu_ram.sv
// ----------------------------------------------------------------------------
// dotu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dotu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/dotu_front.sv
// ----------------------------------------------------------------------------
// dotu_front
// Accepts requests, classifies the operation code and queues them.
// ----------------------------------------------------------------------------
module dotu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_operation,
   input  logic [5:0]        req_slot,
   input  logic [31:0]       req_period_ms,
   input  logic              req_repeat_req,
   input  logic              req_restart_now,
   input  logic [63:0]       req_now_ms,
   output logic              cmd_valid,
   output dotu_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   dotu_pkg::cmd_type entry_ff [2];
   dotu_pkg::cmd_type entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   // Decode the operation code; unused codes become a no-op.
   always_comb begin
      entry_in.slot        = req_slot;
      entry_in.period      = req_period_ms;
      entry_in.repeat_req  = req_repeat_req;
      entry_in.restart_now = req_restart_now;
      entry_in.now         = req_now_ms;
      unique case (req_operation)
         dotu_pkg::OP_ADD:     entry_in.op = dotu_pkg::OP_ADD;
         dotu_pkg::OP_CANCEL:  entry_in.op = dotu_pkg::OP_CANCEL;
         dotu_pkg::OP_REFRESH: entry_in.op = dotu_pkg::OP_REFRESH;
         dotu_pkg::OP_RESET:   entry_in.op = dotu_pkg::OP_RESET;
         dotu_pkg::OP_QUERY:   entry_in.op = dotu_pkg::OP_QUERY;
         dotu_pkg::OP_EXPIRE:  entry_in.op = dotu_pkg::OP_EXPIRE;
         default:              entry_in.op = dotu_pkg::OP_NOP;
      endcase
   end

   // Two-entry queue pointers and fill count.
   always_comb begin
      req_full  = (count_ff == 2'd2);
      cmd_valid = (count_ff != 2'd0);
      cmd       = entry_ff[rd_ptr_ff];
      push_ok   = req_push && !req_full;
      pop_ok    = cmd_pop && cmd_valid;
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### rtl/dotu_rsp_queue.sv
// ----------------------------------------------------------------------------
// dotu_rsp_queue
// Two-entry result queue that parts the back end from the result receiver.
// ----------------------------------------------------------------------------
module dotu_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dotu_pkg::rsp_type push_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output dotu_pkg::rsp_type head
);

   dotu_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   // Pointer and count update.
   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head      = entry_ff[rd_ptr_ff];
      push_ok   = push && !full;
      pop_ok    = pop && !empty;
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dotu_back.sv
// ----------------------------------------------------------------------------
// dotu_back
// Executes classified requests against the timer table, scanning the
// deadline and period memories one slot per cycle.
// ----------------------------------------------------------------------------
module dotu_back #(
   parameter int SLOTS = dotu_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       window,
   input  logic              cmd_valid,
   input  dotu_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_push,
   output dotu_pkg::rsp_type rsp,
   input  logic              rsp_full
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = 33;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_RDWAIT = 6'b000100,
      ST_RESET2 = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SCAN_MIN   = 2'd0,
      SCAN_DUE   = 2'd1,
      SCAN_SEL   = 2'd2,
      SCAN_REARM = 2'd3
   } scan_type;

   state_type         state_ff, state_in;
   scan_type          mode_ff, mode_in;
   dotu_pkg::cmd_type cmd_ff, cmd_in;
   dotu_pkg::rsp_type res_ff, res_in;
   logic [SLOTS-1:0]  armed_ff, armed_in;
   logic [SLOTS-1:0]  due_ff, due_in;
   logic [SLOTS-1:0]  fired_ff, fired_in;
   logic [SLOTS-1:0]  recv_ff, recv_in;
   logic              notice_ff, notice_in;
   logic [63:0]       prev_ff, prev_in;
   logic              roll_ff, roll_in;
   logic              exp_act_ff, exp_act_in;
   logic              exp_busy_ff, exp_busy_in;
   logic [63:0]       start_ff, start_in;
   logic              rec_ff, rec_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pv_ff, pv_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic              bv_ff, bv_in;
   logic [63:0]       bdl_ff, bdl_in;
   logic [IW-1:0]     bidx_ff, bidx_in;

   logic              dl_wr_en;
   logic [IW-1:0]     dl_wr_addr;
   logic [63:0]       dl_wr_data;
   logic [63:0]       dl_q;
   logic              pr_wr_en;
   logic [PW-1:0]     pr_wr_data;
   logic [PW-1:0]     pr_q;
   logic [IW-1:0]     rd_addr;

   logic              scan_issue;
   logic              scan_done;
   logic              slot_oor;
   logic [IW-1:0]     slot_idx;
   logic [IW-1:0]     free_idx;
   logic [SLOTS-1:0]  due_left;
   logic              fn_hit;

   // Deadline and period memories; the period word carries the recurring bit.
   dotu_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_addr (rd_addr),
      .rd_data (dl_q)
   );

   dotu_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pr_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (slot_idx),
      .wr_data (pr_wr_data),
      .rd_addr (rd_addr),
      .rd_data (pr_q)
   );

   // Lowest free slot and slot decode.
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!armed_ff[i]) begin
            free_idx = IW'(i);
         end
      end
      slot_oor = ({1'b0, cmd_ff.slot} >= 7'(SLOTS));
      slot_idx = (state_ff == ST_EXEC && cmd_ff.op == dotu_pkg::OP_ADD) ?
                 free_idx : cmd_ff.slot[IW-1:0];
   end

   // Scan sequencing: an address is issued and its data is seen in the next cycle.
   always_comb begin
      scan_issue = (state_ff == ST_SCAN) && (scan_ff != CW'(SLOTS));
      scan_done  = (state_ff == ST_SCAN) && !scan_issue && !pv_ff;
      rd_addr    = scan_issue ? scan_ff[IW-1:0] : cmd_ff.slot[IW-1:0];
      due_left   = due_ff;
      due_left[bidx_ff] = 1'b0;
      fn_hit     = bv_ff && (bidx_ff == tgt_ff);
   end

   // Main sequencer.
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cmd_in      = cmd_ff;
      res_in      = res_ff;
      armed_in    = armed_ff;
      due_in      = due_ff;
      fired_in    = fired_ff;
      recv_in     = recv_ff;
      notice_in   = notice_ff;
      prev_in     = prev_ff;
      roll_in     = roll_ff;
      exp_act_in  = exp_act_ff;
      exp_busy_in = exp_busy_ff;
      start_in    = start_ff;
      rec_in      = rec_ff;
      tgt_in      = tgt_ff;
      scan_in     = scan_ff;
      pv_in       = 1'b0;
      pidx_in     = pidx_ff;
      bv_in       = bv_ff;
      bdl_in      = bdl_ff;
      bidx_in     = bidx_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      dl_wr_en    = 1'b0;
      dl_wr_addr  = slot_idx;
      dl_wr_data  = cmd_ff.now + {32'd0, cmd_ff.period};
      pr_wr_en    = 1'b0;
      pr_wr_data  = {cmd_ff.repeat_req, cmd_ff.period};

      // Result in progress; the activity flag is filled in when it is pushed.
      rsp = res_ff;
      rsp.any_active = exp_busy_ff ? exp_act_ff : (|armed_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in        = '0;
            res_in.status = dotu_pkg::STS_OK;
            res_in.last   = 1'b1;
            state_in      = ST_EMIT;
            case (cmd_ff.op)
               dotu_pkg::OP_ADD: begin
                  if (&armed_ff) begin
                     res_in.status = dotu_pkg::STS_FULL;
                  end else begin
                     dl_wr_en           = 1'b1;
                     pr_wr_en           = 1'b1;
                     armed_in[free_idx] = 1'b1;
                     tgt_in             = free_idx;
                     res_in.timer_id    = 6'(free_idx);
                     if (!notice_ff) begin
                        mode_in  = SCAN_MIN;
                        scan_in  = '0;
                        bv_in    = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
               end
               dotu_pkg::OP_CANCEL: begin
                  if (slot_oor || !armed_ff[slot_idx]) begin
                     res_in.status = dotu_pkg::STS_NOT_ACTIVE;
                  end else begin
                     armed_in[slot_idx] = 1'b0;
                  end
               end
               dotu_pkg::OP_REFRESH: begin
                  if (slot_oor || !armed_ff[slot_idx]) begin
                     res_in.status = dotu_pkg::STS_NOT_ACTIVE;
                  end else begin
                     state_in = ST_RDWAIT;
                  end
               end
               dotu_pkg::OP_RESET: begin
                  if (slot_oor) begin
                     res_in.status = dotu_pkg::STS_NOT_ACTIVE;
                  end else begin
                     state_in = ST_RDWAIT;
                  end
               end
               dotu_pkg::OP_QUERY: begin
                  notice_in = 1'b0;
                  mode_in   = SCAN_MIN;
                  scan_in   = '0;
                  bv_in     = 1'b0;
                  state_in  = ST_SCAN;
               end
               dotu_pkg::OP_EXPIRE: begin
                  if (armed_ff == '0) begin
                     res_in.status = dotu_pkg::STS_NOTHING;
                  end else begin
                     roll_in  = (cmd_ff.now < prev_ff) &&
                                ((prev_ff - cmd_ff.now) > {32'd0, window});
                     prev_in  = cmd_ff.now;
                     due_in   = '0;
                     fired_in = '0;
                     mode_in  = SCAN_DUE;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_RDWAIT: begin
            // Stored deadline and period of the addressed slot are valid here.
            state_in = ST_EMIT;
            if (cmd_ff.op == dotu_pkg::OP_REFRESH) begin
               dl_wr_en   = 1'b1;
               dl_wr_data = cmd_ff.now + {32'd0, pr_q[31:0]};
            end else if (cmd_ff.period == pr_q[31:0] && !cmd_ff.restart_now) begin
               res_in.status = dotu_pkg::STS_OK;
            end else if (!armed_ff[slot_idx]) begin
               res_in.status = dotu_pkg::STS_NOT_ACTIVE;
            end else begin
               start_in = cmd_ff.restart_now ? cmd_ff.now :
                          (dl_q - {32'd0, pr_q[31:0]});
               rec_in   = pr_q[32];
               state_in = ST_RESET2;
            end
         end

         ST_RESET2: begin
            dl_wr_en   = 1'b1;
            dl_wr_data = start_ff + {32'd0, cmd_ff.period};
            pr_wr_en   = 1'b1;
            pr_wr_data = {rec_ff, cmd_ff.period};
            tgt_in     = slot_idx;
            if (notice_ff) begin
               state_in = ST_EMIT;
            end else begin
               mode_in  = SCAN_MIN;
               scan_in  = '0;
               bv_in    = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (scan_issue) begin
               pv_in   = 1'b1;
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
            end
            // Work on the slot whose memory data has just arrived.
            if (pv_ff) begin
               case (mode_ff)
                  SCAN_MIN: begin
                     if (armed_ff[pidx_ff] && (!bv_ff || dl_q < bdl_ff)) begin
                        bv_in   = 1'b1;
                        bdl_in  = dl_q;
                        bidx_in = pidx_ff;
                     end
                  end
                  SCAN_DUE: begin
                     due_in[pidx_ff]   = armed_ff[pidx_ff] && (roll_ff || dl_q <= cmd_ff.now);
                     fired_in[pidx_ff] = armed_ff[pidx_ff] && (roll_ff || dl_q <= cmd_ff.now);
                     recv_in[pidx_ff]  = pr_q[32];
                  end
                  SCAN_SEL: begin
                     if (due_ff[pidx_ff] && (!bv_ff || dl_q < bdl_ff)) begin
                        bv_in   = 1'b1;
                        bdl_in  = dl_q;
                        bidx_in = pidx_ff;
                     end
                  end
                  default: begin
                     if (fired_ff[pidx_ff] && recv_ff[pidx_ff]) begin
                        dl_wr_en   = 1'b1;
                        dl_wr_addr = pidx_ff;
                        dl_wr_data = cmd_ff.now + {32'd0, pr_q[31:0]};
                     end
                  end
               endcase
            end
            // End of a full pass over the table.
            if (scan_done) begin
               case (mode_ff)
                  SCAN_MIN: begin
                     state_in = ST_EMIT;
                     if (cmd_ff.op == dotu_pkg::OP_QUERY) begin
                        if (!bv_ff) begin
                           res_in.remaining = dotu_pkg::EMPTY_REMAINING;
                        end else if (cmd_ff.now >= bdl_ff) begin
                           res_in.remaining = '0;
                        end else begin
                           res_in.remaining = bdl_ff - cmd_ff.now;
                        end
                     end else begin
                        res_in.front_notice = fn_hit;
                        notice_in           = fn_hit;
                     end
                  end
                  SCAN_DUE: begin
                     if (due_ff == '0) begin
                        res_in.status = dotu_pkg::STS_NOTHING;
                        state_in      = ST_EMIT;
                     end else begin
                        exp_act_in  = |(armed_ff & (~due_ff | recv_ff));
                        exp_busy_in = 1'b1;
                        mode_in     = SCAN_SEL;
                        scan_in     = '0;
                        bv_in       = 1'b0;
                     end
                  end
                  SCAN_SEL: begin
                     res_in.status   = dotu_pkg::STS_OK;
                     res_in.timer_id = 6'(bidx_ff);
                     res_in.last     = (due_left == '0);
                     due_in          = due_left;
                     state_in        = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (!exp_busy_ff) begin
                  state_in = ST_IDLE;
               end else if (due_ff != '0) begin
                  mode_in  = SCAN_SEL;
                  scan_in  = '0;
                  bv_in    = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  // All due timers delivered: disarm one-shots, rearm the rest.
                  armed_in    = armed_ff & ~(fired_ff & ~recv_ff);
                  exp_busy_in = 1'b0;
                  mode_in     = SCAN_REARM;
                  scan_in     = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         armed_ff    <= '0;
         notice_ff   <= 1'b0;
         prev_ff     <= '0;
         exp_busy_ff <= 1'b0;
         pv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         armed_ff    <= armed_in;
         notice_ff   <= notice_in;
         prev_ff     <= prev_in;
         exp_busy_ff <= exp_busy_in;
         pv_ff       <= pv_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      due_ff     <= due_in;
      fired_ff   <= fired_in;
      recv_ff    <= recv_in;
      roll_ff    <= roll_in;
      exp_act_ff <= exp_act_in;
      start_ff   <= start_in;
      rec_ff     <= rec_in;
      tgt_ff     <= tgt_in;
      scan_ff    <= scan_in;
      pidx_ff    <= pidx_in;
      bv_ff      <= bv_in;
      bdl_ff     <= bdl_in;
      bidx_ff    <= bidx_in;
   end

endmodule

### rtl/dotu_checker.sv
// ----------------------------------------------------------------------------
// dotu_checker
// Port-level checks on the timer table unit, bound to the top level.
// ----------------------------------------------------------------------------
module dotu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic [1:0]  rsp_status,
   input logic [5:0]  rsp_timer_id,
   input logic [63:0] rsp_remaining_ms,
   input logic        rsp_front_notice,
   input logic        rsp_last
);

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A full table never reports a slot.
   a_full_id: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == dotu_pkg::STS_FULL) |-> (rsp_timer_id == 6'd0))
      else $error("table full result carries a slot");

   // Failed results carry no remaining time and end their request.
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != dotu_pkg::STS_OK) |->
         (rsp_remaining_ms == 64'd0 && rsp_last))
      else $error("failed result malformed");

   // A front notice belongs to a successful single result.
   a_notice_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_front_notice) |->
         (rsp_status == dotu_pkg::STS_OK && rsp_last && rsp_remaining_ms == 64'd0))
      else $error("front notice on wrong result");

endmodule

bind deadline_ordered_timer_table_unit dotu_checker u_dotu_checker (.*);
